### sv/sst_pkg.sv
`default_nettype none

package sst_pkg;

  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 11;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [VALUE_W-1:0] value;
  } sst_in_t;

  typedef struct packed {
    status_t           status;
    logic              present;
    logic [SIZE_W-1:0] size;
  } sst_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT,
    S_SHIFT_WR,
    S_PLACE,
    S_FINISH
  } sst_state_t;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic place;
    logic finish;
  } sst_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  srch_more;
    logic  hit;
    logic  full;
    logic  shift_done;
    logic  out_busy;
  } sst_stat_t;

endpackage

`default_nettype wire

### sv/sst_dp.sv
`default_nettype none

module sst_dp #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sst_pkg::sst_in_t  in_data,
  input  sst_pkg::sst_cmd_t cmd,
  output sst_pkg::sst_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output sst_pkg::sst_out_t out_data
);
  import sst_pkg::*;

  localparam int VW = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [VW-1:0] mem [CAPACITY];

  mode_t         mode_r;
  logic [VW-1:0] value_r;
  logic [CW-1:0] lo_r;
  logic [CW-1:0] hi_r;
  logic [CW-1:0] mid_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] count_r;
  logic          hit_r;
  logic [VW-1:0] rdata_r;
  logic          out_valid_r;
  sst_out_t      out_data_r;

  logic [CW-1:0] mid;
  logic          is_insert;
  logic          full;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic [CW-1:0] count_nxt;
  status_t       status_nxt;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign is_insert = (mode_r == MODE_INSERT);
  assign full      = (count_r == CAP_C);

  always_comb begin
    rd_en   = cmd.srch_rd | cmd.shift_rd;
    rd_addr = mid[AW-1:0];
    if (cmd.shift_rd) begin
      rd_addr = is_insert ? AW'(idx_r - ONE_C) : AW'(idx_r + ONE_C);
    end
    wr_en   = cmd.shift_wr | cmd.place;
    wr_addr = cmd.place ? lo_r[AW-1:0] : idx_r[AW-1:0];
    wr_data = cmd.place ? value_r : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // result and new size, evaluated at finish
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    case (mode_r)
      MODE_INSERT: begin
        if (hit_r) begin
          status_nxt = ST_DUPLICATE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + ONE_C;
        end
      end
      MODE_ERASE: begin
        if (hit_r) begin
          count_nxt = count_r - ONE_C;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      MODE_QUERY: begin
        count_nxt = count_r;
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_data.mode;
      value_r <= in_data.value[VW-1:0];
      lo_r    <= '0;
      hi_r    <= count_r;
      hit_r   <= 1'b0;
    end
    if (cmd.srch_rd) begin
      mid_r <= mid;
    end
    if (cmd.srch_upd) begin
      if (rdata_r < value_r) begin
        lo_r <= mid_r + ONE_C;
      end else begin
        hi_r <= mid_r;
      end
      if (rdata_r == value_r) begin
        hit_r <= 1'b1;
      end
    end
    if (cmd.shift_init) begin
      idx_r <= is_insert ? count_r : lo_r;
    end
    if (cmd.shift_wr) begin
      idx_r <= is_insert ? (idx_r - ONE_C) : (idx_r + ONE_C);
    end
    if (cmd.finish) begin
      out_data_r.status  <= status_nxt;
      out_data_r.present <= hit_r;
      out_data_r.size    <= SIZE_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.mode       = mode_r;
    stat.srch_more  = (lo_r < hi_r);
    stat.hit        = hit_r;
    stat.full       = full;
    stat.shift_done = is_insert ? (idx_r == lo_r) : ((idx_r + ONE_C) >= count_r);
    stat.out_busy   = out_valid_r & ~out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### sv/sst_ctrl.sv
`default_nettype none

module sst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sst_pkg::sst_stat_t stat,
  output sst_pkg::sst_cmd_t  cmd
);
  import sst_pkg::*;

  sst_state_t state_r;
  sst_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      // binary search for the lower bound
      S_SRCH: begin
        if (stat.srch_more) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SRCH_CMP;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_DECIDE: begin
        if ((stat.mode == MODE_INSERT) && !stat.hit && !stat.full) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else if ((stat.mode == MODE_ERASE) && stat.hit) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      // one entry moved per read/write pair
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = (stat.mode == MODE_INSERT) ? S_PLACE : S_FINISH;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/sorted_set_table.sv
// sorted_set_table: a set of distinct unsigned values held in ascending order
// in one single-port-read, single-port-write memory of CAPACITY entries.
// input channel in_valid/in_ready/in_data: one item = mode (insert, erase,
// membership query, clear) and a value; only the low VALUE_WIDTH bits count.
// result channel out_valid/out_ready/out_data: one item per input item, with
// status, whether the value was held before, and the size afterwards.
// one item at a time: a binary search over the held entries (one memory
// read per probe), then, for an insert of a new value into a set that is not
// full or an erase of a held value, a move of every entry from the position
// upward (insert) or above it (erase), one read and one write per entry
// through the memory port. the next item is taken at the earliest in the
// cycle after the result is loaded; the result sits in an output register,
// so the next item is taken while it waits; if the receiver still holds the
// previous result when the next one is ready, the block waits in its final
// step and takes no new item.
// reset (rst_n low, synchronous) empties the set and drops any pending
// result; memory contents are not cleared, only entries below the size are
// ever read.
`default_nettype none

module sorted_set_table #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sst_pkg::sst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sst_pkg::sst_out_t out_data
);
  import sst_pkg::*;

  sst_cmd_t  cmd;
  sst_stat_t stat;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sst_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sv/sst_checker.sv
`default_nettype none

module sst_checker #(
  parameter int CAPACITY = 1024
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input sst_pkg::sst_out_t out_data
);
  import sst_pkg::*;

  localparam logic SIZE_FITS = (CAPACITY < (1 << SIZE_W));
  localparam logic [SIZE_W-1:0] CAP_S = SIZE_W'(CAPACITY);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_dup_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_DUPLICATE) |-> out_data.present)
    else $error("duplicate without prior membership");

  a_notfound_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NOT_FOUND) |-> !out_data.present)
    else $error("not found with prior membership");

  a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) && SIZE_FITS
      |-> !out_data.present && (out_data.size == CAP_S))
    else $error("full status with wrong size");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SIZE_FITS |-> out_data.size <= CAP_S)
    else $error("size above capacity");

endmodule

bind sorted_set_table sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### tb/sv/tb.sv
`default_nettype none

module tb;
  import sst_pkg::*;

  localparam int CAP = 1024;
  localparam int FILL = 64;
  localparam int LIMIT = 12_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sst_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sst_out_t out_data;

  sst_in_t pending[$];
  sst_out_t result_due[$];
  logic [31:0] held_vals[$];
  logic [31:0] value_pool[40];
  logic [31:0] fill_vals[FILL];

  int gap_left = 0;
  int burst_left = 0;
  int bad_count = 0;
  int cycles = 0;
  logic [8:0] rdy_cnt = '0;

  sorted_set_table u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic sst_out_t set_op_result(sst_in_t op);
    sst_out_t r;
    int pos;
    logic hit;
    pos = 0;
    while (pos < held_vals.size() && held_vals[pos] < op.value) pos++;
    hit = (pos < held_vals.size()) && (held_vals[pos] == op.value);
    r.status = ST_OK;
    r.present = hit;
    case (op.mode)
      MODE_INSERT: begin
        if (hit) r.status = ST_DUPLICATE;
        else if (held_vals.size() >= CAP) r.status = ST_FULL;
        else held_vals.insert(pos, op.value);
      end
      MODE_ERASE: begin
        if (!hit) r.status = ST_NOT_FOUND;
        else held_vals.delete(pos);
      end
      MODE_QUERY: begin
      end
      default: begin
        held_vals.delete();
      end
    endcase
    r.size = SIZE_W'(held_vals.size());
    return r;
  endfunction

  task automatic queue_op(mode_t m, logic [31:0] v);
    sst_in_t it;
    it.mode = m;
    it.value = v;
    pending.push_back(it);
  endtask

  task automatic drain_wait();
    while (pending.size() != 0 || in_valid || result_due.size() != 0) @(negedge clk);
  endtask

  task automatic report_bad(string what, sst_out_t w, sst_out_t g);
    bad_count++;
    if (bad_count <= 10)
      $display("%s: exp status=%0d present=%0b size=%0d, got status=%0d present=%0b size=%0d",
               what, w.status, w.present, w.size, g.status, g.present, g.size);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return value_pool[$urandom_range(0, 39)];
    if (r < 86) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // sender: bursts and gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) result_due.push_back(set_op_result(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_data <= pending.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    rdy_cnt <= rdy_cnt + 9'd1;
    case (rdy_cnt[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rdy_cnt[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin : mon
    sst_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_due.size() == 0) begin
        want = '0;
        report_bad("unexpected item", want, out_data);
      end else begin
        want = result_due.pop_front();
        if (out_data.status !== want.status || out_data.present !== want.present ||
            out_data.size !== want.size)
          report_bad("mismatch", want, out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int r;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty set corner cases
    queue_op(MODE_QUERY, 32'h0000_0000);
    queue_op(MODE_ERASE, 32'h0000_0005);
    queue_op(MODE_CLEAR, 32'h0000_0000);
    queue_op(MODE_INSERT, 32'hFFFF_FFFF);
    queue_op(MODE_INSERT, 32'h0000_0000);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_INSERT, 32'h0000_0000);
    queue_op(MODE_INSERT, 32'hFFFF_FFFF);
    queue_op(MODE_QUERY, 32'h0000_0000);
    queue_op(MODE_QUERY, 32'hFFFF_FFFF);
    queue_op(MODE_QUERY, 32'h0000_0007);
    queue_op(MODE_ERASE, 32'h8000_0000);
    queue_op(MODE_ERASE, 32'h0000_0005);
    queue_op(MODE_INSERT, 32'h5555_5555);
    queue_op(MODE_INSERT, 32'hAAAA_AAAA);
    queue_op(MODE_ERASE, 32'h0000_0000);
    queue_op(MODE_CLEAR, 32'h5555_5555);
    queue_op(MODE_CLEAR, 32'h0000_0003);
    queue_op(MODE_QUERY, 32'h5555_5555);
    drain_wait();

    // partial fill in ascending order, low bit kept clear
    for (int i = 0; i < FILL; i++) begin
      r = $urandom;
      fill_vals[i] = {10'(i), r[21:1], 1'b0};
      queue_op(MODE_INSERT, fill_vals[i]);
    end
    queue_op(MODE_INSERT, fill_vals[5] | 32'd1);
    queue_op(MODE_INSERT, fill_vals[50]);
    queue_op(MODE_QUERY, fill_vals[7]);
    queue_op(MODE_QUERY, fill_vals[7] | 32'd1);
    queue_op(MODE_ERASE, fill_vals[0]);
    queue_op(MODE_INSERT, fill_vals[0]);
    queue_op(MODE_INSERT, fill_vals[3] | 32'd1);
    queue_op(MODE_ERASE, fill_vals[3] | 32'd1);
    queue_op(MODE_ERASE, fill_vals[FILL-1]);
    queue_op(MODE_INSERT, fill_vals[FILL-1]);
    queue_op(MODE_CLEAR, fill_vals[10]);
    drain_wait();

    for (int n = 0; n < 196; n++) begin
      r = $urandom_range(0, 99);
      if (r < 42) queue_op(MODE_INSERT, pick_value());
      else if (r < 72) queue_op(MODE_ERASE, pick_value());
      else if (r < 96) queue_op(MODE_QUERY, pick_value());
      else queue_op(MODE_CLEAR, pick_value());
      if (n == 100) drain_wait();
    end

    drain_wait();
    repeat (100) @(negedge clk);
    bad_count += result_due.size();
    if (bad_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/sst_pkg.sv
sv/sst_dp.sv
sv/sst_ctrl.sv
sv/sorted_set_table.sv
sv/sst_checker.sv
tb/sv/tb.sv
